FILE: hdl/mavg_pkg.sv
// Shared constants, types and helpers for the moving average ring block.
// No dependencies.
`default_nettype none

package mavg_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int SUM_BITS    = 23;
    localparam int OUT_BITS    = 16;
    localparam int WIN_BITS    = 7;
    localparam int POS_BITS    = $clog2(MAX_WINDOW);
    localparam int STEP_BITS   = $clog2(SUM_BITS);

    typedef enum logic {
        FUNC_ADD    = 1'b0,
        FUNC_REFILL = 1'b1
    } t_func;

    // zero acts as one, anything above the ring depth saturates to it
    function automatic logic [WIN_BITS-1:0] eff_window(input logic [WIN_BITS-1:0] raw);
        logic [WIN_BITS-1:0] w;
        w = raw;
        if (raw == '0) begin
            w = WIN_BITS'(1);
        end else if (raw > WIN_BITS'(MAX_WINDOW)) begin
            w = WIN_BITS'(MAX_WINDOW);
        end
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/mavg_div.sv
// Bit-serial signed divider of the running sum by the window size, with
// truncation toward zero and saturation to the output range. Uses mavg_pkg.
`default_nettype none

module mavg_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [mavg_pkg::SUM_BITS-1:0] i_sum,
    input  wire logic [mavg_pkg::WIN_BITS-1:0] i_divisor,
    output logic                               o_done,
    output logic [mavg_pkg::OUT_BITS-1:0]      o_quotient
);
    import mavg_pkg::*;

    localparam logic [SUM_BITS-1:0] POS_LIMIT = SUM_BITS'((1 << (OUT_BITS - 1)) - 1);
    localparam logic [SUM_BITS-1:0] NEG_LIMIT = SUM_BITS'(1 << (OUT_BITS - 1));
    localparam logic [OUT_BITS-1:0] OUT_MAX   = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam logic [OUT_BITS-1:0] OUT_MIN   = {1'b1, {(OUT_BITS-1){1'b0}}};

    logic                  r_busy;
    logic                  r_fin;
    logic                  r_done;
    logic [STEP_BITS-1:0]  r_step;
    logic                  r_neg;
    logic [WIN_BITS-1:0]   r_div;
    logic [WIN_BITS-1:0]   r_rem;
    logic [SUM_BITS-1:0]   r_quo;
    logic [OUT_BITS-1:0]   r_q_out;

    logic [WIN_BITS:0]     w_trial;
    logic [WIN_BITS:0]     w_diff;
    logic                  w_ge;
    logic [SUM_BITS-1:0]   w_mag;
    logic [OUT_BITS-1:0]   w_neg_q;

    assign w_trial = {r_rem, r_quo[SUM_BITS-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_mag   = i_sum[SUM_BITS-1] ? (~i_sum + SUM_BITS'(1)) : i_sum;
    assign w_neg_q = ~r_quo[OUT_BITS-1:0] + OUT_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_BITS'(SUM_BITS - 1);
            end else if (r_busy) begin
                r_step <= r_step - STEP_BITS'(1);
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
            if (r_fin) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_sum[SUM_BITS-1];
            r_div <= i_divisor;
            r_rem <= '0;
            r_quo <= w_mag;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[WIN_BITS-1:0] : w_trial[WIN_BITS-1:0];
            r_quo <= {r_quo[SUM_BITS-2:0], w_ge};
        end
        if (r_fin) begin
            if (!r_neg) begin
                r_q_out <= (r_quo > POS_LIMIT) ? OUT_MAX : r_quo[OUT_BITS-1:0];
            end else begin
                r_q_out <= (r_quo > NEG_LIMIT) ? OUT_MIN : w_neg_q;
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q_out;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy && !r_fin)
        else $error("divider started while busy");

    a_done_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |=> r_done && !r_busy)
        else $error("divider done not after final step");

    a_fin_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |=> !r_fin)
        else $error("final step lasted more than one cycle");

endmodule

`default_nettype wire

FILE: hdl/moving_average_ring_core.sv
// Top level of the boxcar moving average: sample ring, running sum,
// sequencer and output register. Uses mavg_pkg and mavg_div.
//
// channel  dir  handshake                      payload
// cfg      in   i_cfg_valid / o_cfg_ready      i_cfg_window_size
// in       in   i_in_valid  / o_in_ready       i_func, i_value
// out      out  o_out_valid / i_out_ready      o_average
//
// Add item: the result is set by the 23-step serial divider.
// Refill item: one ring entry written per cycle, entries 0 to window size - 1.
// Reset clears ring valid bits, sum, position; window size returns to 64.
// A result waits in the output register; the next item is taken meanwhile,
// and the sequencer holds its finished result until that register is free.
`default_nettype none

module moving_average_ring_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [mavg_pkg::WIN_BITS-1:0]    i_cfg_window_size,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic                             i_func,
    input  wire logic signed [mavg_pkg::SAMPLE_BITS-1:0] i_value,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic signed [mavg_pkg::OUT_BITS-1:0]  o_average
);
    import mavg_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_FILL,
        S_PUT
    } t_state;

    t_state                  r_state;
    logic [WIN_BITS-1:0]     r_win_reg;
    logic [WIN_BITS-1:0]     r_win;
    logic [POS_BITS-1:0]     r_pos;
    logic [POS_BITS-1:0]     r_cnt;
    logic [SUM_BITS-1:0]     r_sum;
    logic [SAMPLE_BITS-1:0]  r_value;
    logic [OUT_BITS-1:0]     r_result;
    logic                    r_out_valid;
    logic [OUT_BITS-1:0]     r_average;
    logic [MAX_WINDOW-1:0]   r_valid;
    logic [SAMPLE_BITS-1:0]  r_mem [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0]  r_rd_data;
    logic                    r_rd_vld;

    logic                    w_in_acc;
    logic [WIN_BITS-1:0]     w_win_eff;
    logic signed [SUM_BITS:0] w_prod;
    logic [SAMPLE_BITS-1:0]  w_old;
    logic [SUM_BITS-1:0]     n_sum;
    logic [WIN_BITS-1:0]     w_pos_inc;
    logic                    w_wr_en;
    logic [POS_BITS-1:0]     w_wr_addr;
    logic                    w_out_free;
    logic                    w_div_done;
    logic [OUT_BITS-1:0]     w_div_q;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_win_eff   = eff_window(r_win_reg);
    assign w_prod      = $signed({{(SUM_BITS+1-SAMPLE_BITS){i_value[SAMPLE_BITS-1]}}, i_value})
                         * $signed({{(SUM_BITS+1-WIN_BITS){1'b0}}, w_win_eff});
    assign w_old       = r_rd_vld ? r_rd_data : '0;
    assign n_sum       = r_sum + {{(SUM_BITS-SAMPLE_BITS){r_value[SAMPLE_BITS-1]}}, r_value}
                         - {{(SUM_BITS-SAMPLE_BITS){w_old[SAMPLE_BITS-1]}}, w_old};
    assign w_pos_inc   = {1'b0, r_pos} + WIN_BITS'(1);
    assign w_wr_en     = (r_state == S_READ) || (r_state == S_FILL);
    assign w_wr_addr   = (r_state == S_FILL) ? r_cnt : r_pos;
    assign w_out_free  = !r_out_valid || i_out_ready;

    mavg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_READ),
        .i_sum      (n_sum),
        .i_divisor  (r_win),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_win_reg   <= WIN_BITS'(MAX_WINDOW);
            r_pos       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_win_reg <= i_cfg_window_size;
            end
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_wr_en) begin
                r_valid[w_wr_addr] <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (t_func'(i_func) == FUNC_REFILL) begin
                            r_sum   <= w_prod[SUM_BITS-1:0];
                            r_pos   <= '0;
                            r_state <= S_FILL;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_sum   <= n_sum;
                    r_pos   <= (w_pos_inc >= r_win) ? '0 : w_pos_inc[POS_BITS-1:0];
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_PUT;
                    end
                end
                S_FILL: begin
                    if ({1'b0, r_cnt} == r_win - WIN_BITS'(1)) begin
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_value   <= i_value;
            r_win     <= w_win_eff;
            r_cnt     <= '0;
            r_rd_data <= r_mem[r_pos];
            r_rd_vld  <= r_valid[r_pos];
            r_result  <= i_value;
        end
        if (r_state == S_FILL) begin
            r_cnt <= r_cnt + POS_BITS'(1);
        end
        if (w_div_done) begin
            r_result <= w_div_q;
        end
        if ((r_state == S_PUT) && w_out_free) begin
            r_average <= r_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= r_value;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_average   = r_average;

    a_add_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (t_func'(i_func) == FUNC_ADD) |=> r_state == S_READ)
        else $error("add item did not go to ring read");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> ({1'b0, r_cnt} < r_win))
        else $error("refill walked past the window");

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV)
        else $error("divider result outside the wait state");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_PUT)
        else $error("result shown without a finished item");

endmodule

`default_nettype wire
